/* rtl/core/ncf_pkg.sv */
// ----------------------------------------------------------------------------
// ncf_pkg
// Shared types and constants of the negative cycle finder: sequencer states,
// operation codes and fixed field widths.
// ----------------------------------------------------------------------------
package ncf_pkg;

    // fixed field widths of the request and result
    localparam int NODE_FIELD_W = 4;
    localparam int WEIGHT_W     = 32;
    localparam int NCOUNT_W     = 5;

    // reset value of the node count register
    localparam logic [NCOUNT_W-1:0] NUM_NODES_RESET = 5'd16;

    // cycle buffer depth, walk is capped one short of it
    localparam int PATH_DEPTH = 17;
    localparam int PATH_W     = 5;

    // request operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_FETCH,
        ST_SWEEP,
        ST_TRACE_RD,
        ST_TRACE_CHK,
        ST_GATHER_RD,
        ST_GATHER_CHK,
        ST_EMIT,
        ST_NONE
    } t_state;

endpackage

/* rtl/core/ncf_ram.sv */
// ----------------------------------------------------------------------------
// ncf_ram
// Generic simple dual port RAM: one write port, one read port and
// registered read data.
// ----------------------------------------------------------------------------
module ncf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/negative_cycle_finder_top.sv */
// ----------------------------------------------------------------------------
// negative_cycle_finder_top
// Bellman-Ford negative cycle search over an adjacency matrix held in RAM.
// Loads write one edge; a search relaxes all edges n-1 times, finds
// the first edge that still relaxes, walks back the predecessors and emits
// the cycle in forward order with its start node repeated.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------
//   in      | input     | i_in_valid / o_in_stall | op, nodes, edge, source
//   out     | output    | o_out_valid/i_out_stall | found, loop_node, last
//   cfg     | input     | i_cfg_we                | num_nodes
//
// A load writes its edge from the idle state. A search with n nodes first
// clears all MAX_NODES node RAM entries, then runs n-1 relaxation passes
// and a final pass, each at one edge per cycle apart from a tail node fetch
// per row; each trace and gather step reads a node and then checks it, and
// results go out one per cycle unless the result channel stalls.
// After reset a clearing pass wipes all MAX_NODES*MAX_NODES entries of the
// edge RAM; no request is taken during it. A stalled result keeps the block
// in its emit state; the last result may wait while a new request is taken.
// ----------------------------------------------------------------------------
module negative_cycle_finder_top #(
    parameter int MAX_NODES = 16,
    parameter int DIST_BITS = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [3:0]  i_from_node,
    input  logic [3:0]  i_to_node,
    input  logic        i_edge_present,
    input  logic [31:0] i_edge_weight,
    input  logic [3:0]  i_source_node,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_found,
    output logic [3:0]  o_loop_node,
    output logic        o_last
);

    localparam int NW     = $clog2(MAX_NODES);
    localparam int CW     = $clog2(MAX_NODES + 1);
    localparam int EDEPTH = MAX_NODES * MAX_NODES;
    localparam int EAW    = $clog2(EDEPTH);
    localparam int EW     = ncf_pkg::WEIGHT_W + 1;
    localparam int NDW    = DIST_BITS + NW + 2;

    // edge address of row u, column v
    function automatic logic [EAW-1:0] edge_addr(input logic [NW-1:0] u,
                                                 input logic [NW-1:0] v);
        int a;
        begin
            a = int'(u) * MAX_NODES + int'(v);
            edge_addr = EAW'(a);
        end
    endfunction

    ncf_pkg::t_state r_state, n_state;

    logic [ncf_pkg::NCOUNT_W-1:0] r_num_nodes;
    logic [EAW-1:0]               r_clr, n_clr;
    logic [NW-1:0]                r_src, n_src;
    logic [NW-1:0]                r_u, n_u;
    logic [NW-1:0]                r_v, n_v;
    logic [NW-1:0]                r_ev, n_ev;
    logic                         r_v_live, n_v_live;
    logic                         r_ev_valid, n_ev_valid;
    logic                         r_first, n_first;
    logic                         r_final, n_final;
    logic [CW-1:0]                r_pass, n_pass;
    logic                         r_ud_reached, n_ud_reached;
    logic [DIST_BITS-1:0]         r_ud_dist, n_ud_dist;
    logic [NW-1:0]                r_curr, n_curr;
    logic [NW-1:0]                r_start, n_start;
    logic [CW-1:0]                r_i, n_i;
    logic [ncf_pkg::PATH_W-1:0]   r_cnt, n_cnt;
    logic [ncf_pkg::PATH_W-1:0]   r_k, n_k;
    logic [NW-1:0]                r_path [ncf_pkg::PATH_DEPTH];
    logic [NW-1:0]                n_path [ncf_pkg::PATH_DEPTH];
    logic                         r_out_valid, n_out_valid;
    logic                         r_out_found, n_out_found;
    logic [NW-1:0]                r_out_node, n_out_node;
    logic                         r_out_last, n_out_last;

    // memory ports
    logic             edge_we;
    logic [EAW-1:0]   edge_waddr;
    logic [EW-1:0]    edge_wdata;
    logic [EAW-1:0]   edge_raddr;
    logic [EW-1:0]    edge_rdata;
    logic             node_we;
    logic [NW-1:0]    node_waddr;
    logic [NDW-1:0]   node_wdata;
    logic [NW-1:0]    node_raddr;
    logic [NDW-1:0]   node_rdata;

    // node word fields
    logic                 w_rd_reached;
    logic                 w_rd_pv;
    logic [NW-1:0]        w_rd_pred;
    logic [DIST_BITS-1:0] w_rd_dist;

    logic [CW-1:0]           w_n;
    logic [NW-1:0]           w_last_node;
    logic                    w_in_accept;
    logic                    w_out_free;
    logic signed [DIST_BITS:0]   w_sum;
    logic signed [DIST_BITS-1:0] w_cand;
    logic                    w_relax;
    logic [ncf_pkg::PATH_W-1:0] w_c1;

    ncf_ram #(.WIDTH(EW), .DEPTH(EDEPTH)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (edge_waddr),
        .i_wdata (edge_wdata),
        .i_raddr (edge_raddr),
        .o_rdata (edge_rdata)
    );

    ncf_ram #(.WIDTH(NDW), .DEPTH(MAX_NODES)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

    assign w_rd_reached = node_rdata[NDW-1];
    assign w_rd_pv      = node_rdata[NDW-2];
    assign w_rd_pred    = node_rdata[DIST_BITS+NW-1:DIST_BITS];
    assign w_rd_dist    = node_rdata[DIST_BITS-1:0];

    // effective node count
    always_comb begin
        if (r_num_nodes == '0) begin
            w_n = CW'(1);
        end else if (int'(r_num_nodes) > MAX_NODES) begin
            w_n = CW'(MAX_NODES);
        end else begin
            w_n = CW'(r_num_nodes);
        end
    end

    assign w_last_node = NW'(w_n - CW'(1));
    assign w_in_accept = i_in_valid && (r_state == ncf_pkg::ST_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // saturating distance sum and relax test
    assign w_sum = $signed({r_ud_dist[DIST_BITS-1], r_ud_dist})
                 + $signed({{(DIST_BITS + 1 - ncf_pkg::WEIGHT_W){edge_rdata[31]}},
                            edge_rdata[31:0]});
    always_comb begin
        if (w_sum[DIST_BITS] != w_sum[DIST_BITS-1]) begin
            w_cand = w_sum[DIST_BITS] ? {1'b1, {(DIST_BITS-1){1'b0}}}
                                      : {1'b0, {(DIST_BITS-1){1'b1}}};
        end else begin
            w_cand = w_sum[DIST_BITS-1:0];
        end
    end
    assign w_relax = edge_rdata[EW-1] && r_ud_reached
                   && (!w_rd_reached || (w_cand < $signed(w_rd_dist)));

    assign w_c1 = r_cnt + ncf_pkg::PATH_W'(1);

    // sequencer next state and memory control
    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_src        = r_src;
        n_u          = r_u;
        n_v          = r_v;
        n_ev         = r_ev;
        n_v_live     = r_v_live;
        n_ev_valid   = r_ev_valid;
        n_first      = r_first;
        n_final      = r_final;
        n_pass       = r_pass;
        n_ud_reached = r_ud_reached;
        n_ud_dist    = r_ud_dist;
        n_curr       = r_curr;
        n_start      = r_start;
        n_i          = r_i;
        n_cnt        = r_cnt;
        n_k          = r_k;
        n_path       = r_path;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_found  = r_out_found;
        n_out_node   = r_out_node;
        n_out_last   = r_out_last;
        edge_we      = 1'b0;
        edge_waddr   = r_clr;
        edge_wdata   = '0;
        edge_raddr   = edge_addr(r_u, r_v);
        node_we      = 1'b0;
        node_waddr   = r_ev;
        node_wdata   = {1'b1, 1'b1, r_u, w_cand};
        node_raddr   = r_v;

        case (r_state)
            // wipe the edge RAM after reset
            ncf_pkg::ST_CLEAR: begin
                edge_we = 1'b1;
                if (r_clr == EAW'(EDEPTH - 1)) begin
                    n_state = ncf_pkg::ST_IDLE;
                end else begin
                    n_clr = r_clr + EAW'(1);
                end
            end
            // take a load or a search request
            ncf_pkg::ST_IDLE: begin
                if (w_in_accept) begin
                    if (i_op == ncf_pkg::OP_LOAD) begin
                        if ((i_from_node != i_to_node)
                            && (int'(i_from_node) < MAX_NODES)
                            && (int'(i_to_node) < MAX_NODES)) begin
                            edge_we    = 1'b1;
                            edge_waddr = edge_addr(NW'(i_from_node), NW'(i_to_node));
                            edge_wdata = {i_edge_present, i_edge_weight};
                        end
                    end else if (int'(i_source_node) >= int'(w_n)) begin
                        n_state = ncf_pkg::ST_NONE;
                    end else begin
                        n_src   = NW'(i_source_node);
                        n_v     = '0;
                        n_state = ncf_pkg::ST_INIT;
                    end
                end
            end
            // reset all node entries, source reached at distance zero
            ncf_pkg::ST_INIT: begin
                node_we    = 1'b1;
                node_waddr = r_v;
                node_wdata = (r_v == r_src) ? {1'b1, {(NDW-1){1'b0}}} : '0;
                if (r_v == NW'(MAX_NODES - 1)) begin
                    n_u     = '0;
                    n_pass  = CW'(1);
                    n_final = (w_n == CW'(1));
                    n_state = ncf_pkg::ST_FETCH;
                end else begin
                    n_v = r_v + NW'(1);
                end
            end
            // read the tail node of the row
            ncf_pkg::ST_FETCH: begin
                node_raddr = r_u;
                n_v        = '0;
                n_v_live   = 1'b1;
                n_ev_valid = 1'b0;
                n_first    = 1'b1;
                n_state    = ncf_pkg::ST_SWEEP;
            end
            // one edge per cycle: read head node, relax the previous one
            ncf_pkg::ST_SWEEP: begin
                if (r_first) begin
                    n_ud_reached = w_rd_reached;
                    n_ud_dist    = w_rd_dist;
                    n_first      = 1'b0;
                end
                n_ev_valid = r_v_live;
                n_ev       = r_v;
                if (r_v_live) begin
                    if (r_v == w_last_node) begin
                        n_v_live = 1'b0;
                    end else begin
                        n_v = r_v + NW'(1);
                    end
                end
                if (r_ev_valid) begin
                    if (w_relax && r_final) begin
                        n_curr  = r_ev;
                        n_i     = '0;
                        n_state = ncf_pkg::ST_TRACE_RD;
                    end else begin
                        node_we = w_relax;
                        if (!r_v_live) begin
                            if (r_u == w_last_node) begin
                                n_u = '0;
                                if (r_final) begin
                                    n_state = ncf_pkg::ST_NONE;
                                end else begin
                                    if (r_pass == w_n - CW'(1)) begin
                                        n_final = 1'b1;
                                    end else begin
                                        n_pass = r_pass + CW'(1);
                                    end
                                    n_state = ncf_pkg::ST_FETCH;
                                end
                            end else begin
                                n_u     = r_u + NW'(1);
                                n_state = ncf_pkg::ST_FETCH;
                            end
                        end
                    end
                end
            end
            // step back n times through predecessors
            ncf_pkg::ST_TRACE_RD: begin
                node_raddr = r_curr;
                n_state    = ncf_pkg::ST_TRACE_CHK;
            end
            ncf_pkg::ST_TRACE_CHK: begin
                if (!w_rd_pv) begin
                    n_state = ncf_pkg::ST_NONE;
                end else begin
                    n_curr = w_rd_pred;
                    if (r_i == w_n - CW'(1)) begin
                        n_start = w_rd_pred;
                        n_cnt   = '0;
                        n_state = ncf_pkg::ST_GATHER_RD;
                    end else begin
                        n_i     = r_i + CW'(1);
                        n_state = ncf_pkg::ST_TRACE_RD;
                    end
                end
            end
            // collect the cycle into the path buffer
            ncf_pkg::ST_GATHER_RD: begin
                node_raddr = r_curr;
                n_state    = ncf_pkg::ST_GATHER_CHK;
            end
            ncf_pkg::ST_GATHER_CHK: begin
                n_path[r_cnt] = r_curr;
                if (!w_rd_pv || (w_rd_pred == r_start)
                    || (int'(w_c1) >= ncf_pkg::PATH_DEPTH - 1)) begin
                    n_path[w_c1] = r_start;
                    n_cnt        = w_c1 + ncf_pkg::PATH_W'(1);
                    n_k          = '0;
                    n_state      = ncf_pkg::ST_EMIT;
                end else begin
                    n_curr  = w_rd_pred;
                    n_cnt   = w_c1;
                    n_state = ncf_pkg::ST_GATHER_RD;
                end
            end
            // results in forward order, newest entry first
            ncf_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = 1'b1;
                    n_out_node  = r_path[r_cnt - r_k - ncf_pkg::PATH_W'(1)];
                    n_out_last  = (r_k == r_cnt - ncf_pkg::PATH_W'(1));
                    if (n_out_last) begin
                        n_state = ncf_pkg::ST_IDLE;
                    end else begin
                        n_k = r_k + ncf_pkg::PATH_W'(1);
                    end
                end
            end
            // single not-found result
            ncf_pkg::ST_NONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = 1'b0;
                    n_out_node  = '0;
                    n_out_last  = 1'b1;
                    n_state     = ncf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ncf_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ncf_pkg::ST_CLEAR;
            r_clr        <= '0;
            r_num_nodes  <= ncf_pkg::NUM_NODES_RESET;
            r_out_valid  <= 1'b0;
            r_v_live     <= 1'b0;
            r_ev_valid   <= 1'b0;
            r_first      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_v_live    <= n_v_live;
            r_ev_valid  <= n_ev_valid;
            r_first     <= n_first;
            if (i_cfg_we) begin
                r_num_nodes <= i_cfg_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_src        <= n_src;
        r_u          <= n_u;
        r_v          <= n_v;
        r_ev         <= n_ev;
        r_final      <= n_final;
        r_pass       <= n_pass;
        r_ud_reached <= n_ud_reached;
        r_ud_dist    <= n_ud_dist;
        r_curr       <= n_curr;
        r_start      <= n_start;
        r_i          <= n_i;
        r_cnt        <= n_cnt;
        r_k          <= n_k;
        r_path       <= n_path;
        r_out_found  <= n_out_found;
        r_out_node   <= n_out_node;
        r_out_last   <= n_out_last;
    end

    assign o_in_stall   = (r_state != ncf_pkg::ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_found      = r_out_found;
    assign o_loop_node  = ncf_pkg::NODE_FIELD_W'(r_out_node);
    assign o_last       = r_out_last;

endmodule

/* rtl/core/ncf_checker.sv */
// ----------------------------------------------------------------------------
// ncf_checker
// Port level checks of the negative cycle finder, bound to the top level.
// ----------------------------------------------------------------------------
module ncf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_stall,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       o_found,
    input logic [3:0] o_loop_node,
    input logic       o_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_found) && $stable(o_loop_node) && $stable(o_last))
        else $error("result changed while stalled");

    // a not-found answer is a single closing result
    a_none_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_last && (o_loop_node == 4'd0))
        else $error("malformed not-found result");

    // reset drops the result
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // the edge clearing pass follows reset
    a_rst_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("request taken right after reset");

endmodule

bind negative_cycle_finder_top ncf_checker u_ncf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_stall  (i_out_stall),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .o_found      (o_found),
    .o_loop_node  (o_loop_node),
    .o_last       (o_last)
);
